// ===== hdl/ps2hbt_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2hbt_pkg
// Shared types and constants of the two-wire host byte transceiver.
// ----------------------------------------------------------------------------
package ps2hbt_pkg;

	localparam int CNT_W   = 20;
	localparam int LIMIT_W = 20;
	localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int IN_W    = 16;
	localparam int OUT_W   = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam int RELEASE_TICKS  = 300;
	localparam int CLK_LOW_TICKS  = 300;
	localparam int DATA_LOW_TICKS = 10;
	localparam int STOP_TICKS     = 30;

	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic REG_WRITE_LIMIT = 1'b0;
	localparam logic REG_READ_LIMIT  = 1'b1;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_W_REL,
		PH_W_CLKLO,
		PH_W_DATLO,
		PH_W_WAIT,
		PH_W_HI,
		PH_W_LO,
		PH_W_STOP,
		PH_W_ACK,
		PH_W_LINEIDLE,
		PH_R_WAIT,
		PH_R_START,
		PH_R_LO,
		PH_R_HI,
		PH_R_PAR_LO,
		PH_R_PAR_HI,
		PH_R_STOP_LO,
		PH_R_STOP_HI
	} phase_t;

	// first field in the highest bits, last field in the lowest bits
	typedef struct packed {
		logic       data_line;
		logic       clk_line;
		logic       timeout_enable;
		logic [7:0] tx_byte;
		logic [1:0] cmd;
	} item_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       success;
		logic       done_res;
		logic       busy_res;
		logic       data_pull_low;
		logic       clk_pull_low;
	} result_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] write_wait_limit;
		logic [LIMIT_W-1:0] read_wait_limit;
	} limits_t;

endpackage

// ===== hdl/ps2hbt_cfg.sv =====
// ----------------------------------------------------------------------------
// ps2hbt_cfg
// Timeout limit registers, written through the plain write port.
// ----------------------------------------------------------------------------
module ps2hbt_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [ps2hbt_pkg::LIMIT_W-1:0] cfg_wdata,
	output ps2hbt_pkg::limits_t            limits
);
	import ps2hbt_pkg::*;

	logic [LIMIT_W-1:0] write_limit_q;
	logic [LIMIT_W-1:0] read_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_limit_q <= LIMIT_W'(15000);
			read_limit_q  <= LIMIT_W'(15000);
		end else if (cfg_we) begin
			if (cfg_index == REG_WRITE_LIMIT) begin
				write_limit_q <= cfg_wdata;
			end
			if (cfg_index == REG_READ_LIMIT) begin
				read_limit_q <= cfg_wdata;
			end
		end
	end

	assign limits.write_wait_limit = write_limit_q;
	assign limits.read_wait_limit  = read_limit_q;

endmodule

// ===== hdl/ps2hbt_seq.sv =====
// ----------------------------------------------------------------------------
// ps2hbt_seq
// Write/read sequencer. One tick per step; result reflects post-step state.
// ----------------------------------------------------------------------------
module ps2hbt_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ps2hbt_pkg::item_t     item,
	input  ps2hbt_pkg::limits_t   limits,
	output ps2hbt_pkg::result_t   result
);
	import ps2hbt_pkg::*;

	phase_t           phase_q, phase_d;
	logic [3:0]       bit_index_q, bit_index_d;
	logic [7:0]       shift_q, shift_d;
	logic             parity_q, parity_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             armed_q, armed_d;
	logic             clk_hold_q, clk_hold_d;
	logic             data_hold_q, data_hold_d;
	logic [7:0]       rx_q, rx_d;

	logic [CNT_W-1:0] cnt_inc;
	logic [3:0]       idx_inc;
	logic             w_timeout;
	logic             r_timeout;
	logic             done;
	logic             ok;

	assign cnt_inc   = (count_q == CNT_MAX) ? count_q : count_q + 1'b1;
	assign idx_inc   = bit_index_q + 4'd1;
	assign w_timeout = armed_q && (CMP_W'(cnt_inc) > CMP_W'(limits.write_wait_limit));
	assign r_timeout = armed_q && (CMP_W'(cnt_inc) > CMP_W'(limits.read_wait_limit));

	// next state
	always_comb begin
		phase_d     = phase_q;
		bit_index_d = bit_index_q;
		shift_d     = shift_q;
		parity_d    = parity_q;
		count_d     = count_q;
		armed_d     = armed_q;
		clk_hold_d  = clk_hold_q;
		data_hold_d = data_hold_q;
		rx_d        = rx_q;
		case (phase_q)
			PH_IDLE: begin
				if (item.cmd == CMD_WRITE) begin
					clk_hold_d  = 1'b0;
					data_hold_d = 1'b0;
					shift_d     = item.tx_byte;
					parity_d    = 1'b1;
					bit_index_d = 4'd0;
					armed_d     = item.timeout_enable;
					count_d     = '0;
					phase_d     = PH_W_REL;
				end else if (item.cmd == CMD_READ) begin
					clk_hold_d  = 1'b0;
					data_hold_d = 1'b0;
					rx_d        = 8'd0;
					bit_index_d = 4'd0;
					armed_d     = item.timeout_enable;
					count_d     = '0;
					phase_d     = PH_R_WAIT;
				end
			end
			PH_W_REL: begin
				count_d = cnt_inc;
				if (cnt_inc >= CNT_W'(RELEASE_TICKS)) begin
					clk_hold_d = 1'b1;
					count_d    = '0;
					phase_d    = PH_W_CLKLO;
				end
			end
			PH_W_CLKLO: begin
				count_d = cnt_inc;
				if (cnt_inc >= CNT_W'(CLK_LOW_TICKS)) begin
					data_hold_d = 1'b1;
					count_d     = '0;
					phase_d     = PH_W_DATLO;
				end
			end
			PH_W_DATLO: begin
				count_d = cnt_inc;
				if (cnt_inc >= CNT_W'(DATA_LOW_TICKS)) begin
					clk_hold_d = 1'b0;
					count_d    = '0;
					phase_d    = PH_W_WAIT;
				end
			end
			PH_W_WAIT: begin
				count_d = cnt_inc;
				if (!item.clk_line) begin
					bit_index_d = 4'd0;
					parity_d    = parity_q ^ shift_q[0];
					data_hold_d = !shift_q[0];
					phase_d     = PH_W_HI;
				end else if (w_timeout) begin
					phase_d = PH_IDLE;
				end
			end
			PH_W_HI: begin
				if (item.clk_line) begin
					phase_d = PH_W_LO;
				end
			end
			PH_W_LO: begin
				if (!item.clk_line) begin
					if (bit_index_q < 4'd8) begin
						bit_index_d = idx_inc;
						phase_d     = PH_W_HI;
						if (idx_inc < 4'd8) begin
							parity_d    = parity_q ^ shift_q[idx_inc[2:0]];
							data_hold_d = !shift_q[idx_inc[2:0]];
						end else begin
							data_hold_d = !parity_q;
						end
					end else begin
						count_d = '0;
						phase_d = PH_W_STOP;
					end
				end
			end
			PH_W_STOP: begin
				count_d = cnt_inc;
				if (cnt_inc >= CNT_W'(STOP_TICKS)) begin
					data_hold_d = 1'b0;
					phase_d     = PH_W_ACK;
				end
			end
			PH_W_ACK: begin
				if (!item.clk_line) begin
					phase_d = PH_W_LINEIDLE;
				end
			end
			PH_W_LINEIDLE: begin
				if (item.clk_line && item.data_line) begin
					clk_hold_d = 1'b1;
					phase_d    = PH_IDLE;
				end
			end
			PH_R_WAIT: begin
				count_d = cnt_inc;
				if (!item.clk_line) begin
					phase_d = PH_R_START;
				end else if (r_timeout) begin
					clk_hold_d = 1'b1;
					phase_d    = PH_IDLE;
				end
			end
			PH_R_START: begin
				if (item.clk_line) begin
					bit_index_d = 4'd0;
					phase_d     = PH_R_LO;
				end
			end
			PH_R_LO: begin
				if (!item.clk_line) begin
					if (item.data_line && bit_index_q < 4'd8) begin
						rx_d[bit_index_q[2:0]] = 1'b1;
					end
					phase_d = PH_R_HI;
				end
			end
			PH_R_HI: begin
				if (item.clk_line) begin
					bit_index_d = idx_inc;
					phase_d     = (idx_inc >= 4'd8) ? PH_R_PAR_LO : PH_R_LO;
				end
			end
			PH_R_PAR_LO: begin
				if (!item.clk_line) begin
					phase_d = PH_R_PAR_HI;
				end
			end
			PH_R_PAR_HI: begin
				if (item.clk_line) begin
					phase_d = PH_R_STOP_LO;
				end
			end
			PH_R_STOP_LO: begin
				if (!item.clk_line) begin
					phase_d = PH_R_STOP_HI;
				end
			end
			PH_R_STOP_HI: begin
				if (item.clk_line) begin
					clk_hold_d = 1'b1;
					phase_d    = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		done = 1'b0;
		ok   = 1'b0;
		case (phase_q)
			PH_W_WAIT: begin
				done = item.clk_line && w_timeout;
			end
			PH_W_LINEIDLE: begin
				done = item.clk_line && item.data_line;
				ok   = done;
			end
			PH_R_WAIT: begin
				done = item.clk_line && r_timeout;
			end
			PH_R_STOP_HI: begin
				done = item.clk_line;
				ok   = done;
			end
			default: begin
				done = 1'b0;
				ok   = 1'b0;
			end
		endcase
		result.clk_pull_low  = clk_hold_d;
		result.data_pull_low = data_hold_d;
		result.busy_res      = (phase_d != PH_IDLE);
		result.done_res      = done;
		result.success       = ok;
		result.rx_byte       = rx_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_index_q <= 4'd0;
			shift_q     <= 8'd0;
			parity_q    <= 1'b1;
			count_q     <= '0;
			armed_q     <= 1'b0;
			clk_hold_q  <= 1'b0;
			data_hold_q <= 1'b0;
			rx_q        <= 8'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			bit_index_q <= bit_index_d;
			shift_q     <= shift_d;
			parity_q    <= parity_d;
			count_q     <= count_d;
			armed_q     <= armed_d;
			clk_hold_q  <= clk_hold_d;
			data_hold_q <= data_hold_d;
			rx_q        <= rx_d;
		end
	end

`ifndef SYNTHESIS
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> phase_q == PH_IDLE)
		else $error("sequence finished but phase not idle");

	a_bit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_index_q <= 4'd8)
		else $error("bit index out of range");

	a_read_releases_data: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_R_WAIT || phase_q == PH_R_START || phase_q == PH_R_LO ||
		 phase_q == PH_R_HI || phase_q == PH_R_PAR_LO || phase_q == PH_R_PAR_HI ||
		 phase_q == PH_R_STOP_LO || phase_q == PH_R_STOP_HI) |-> !data_hold_q)
		else $error("data line held during read");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_IDLE && (item.cmd == CMD_WRITE || item.cmd == CMD_READ)
		|=> count_q == '0 && !clk_hold_q && !data_hold_q)
		else $error("sequence start did not clear counter and lines");
`endif

endmodule

// ===== hdl/ps2hbt_seq_top.sv =====
// ----------------------------------------------------------------------------
// ps2hbt_seq_top
// Input register, sequencer step and result register with stream handshake.
// ----------------------------------------------------------------------------
module ps2hbt_seq_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ps2hbt_pkg::item_t            in_item,
	input  ps2hbt_pkg::limits_t          limits,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ps2hbt_pkg::result_t          out_res
);
	import ps2hbt_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_res_q;
	result_t res;
	logic    step;

	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	ps2hbt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.limits (limits),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
		if (step) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

// ===== hdl/ps2_host_byte_transceiver_top.sv =====
// ----------------------------------------------------------------------------
// ps2_host_byte_transceiver_top
// Host-side byte transceiver for the two-wire keyboard/mouse link.
// A transaction is held in the input register, then its result in the result
// register. One tick transaction per clock cycle while the output is not
// stalled; the sequencer state updates once per tick in one registered step.
// Reset: arst_n clears phase to idle, both lines released, limits to 15000.
// ----------------------------------------------------------------------------
module ps2_host_byte_transceiver_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// cmd[1:0], tx_byte[9:2], timeout_enable[10], clk_line[11], data_line[12]
	input  logic [ps2hbt_pkg::IN_W-1:0]    s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// clk_pull_low[0], data_pull_low[1], busy_res[2], done_res[3],
	// success[4], rx_byte[12:5]
	output logic [ps2hbt_pkg::OUT_W-1:0]   m_tdata,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [ps2hbt_pkg::LIMIT_W-1:0] cfg_wdata
);
	import ps2hbt_pkg::*;

	limits_t limits;
	item_t   in_item;
	result_t out_res;

	assign in_item = s_tdata[$bits(item_t)-1:0];
	assign m_tdata = {{(OUT_W - $bits(result_t)){1'b0}}, out_res};

	ps2hbt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.limits    (limits)
	);

	ps2hbt_seq_top u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.limits    (limits),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

endmodule

// ===== tb/tb_ps2_host_byte_transceiver_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ps2_host_byte_transceiver_top
// Self-checking bench for the two-wire host byte transceiver. Tick
// transactions go in on the slave stream, line/status words come back on
// the master stream, one per tick. An in-bench sequencer model predicts
// each status word the directed table does not fix. The table covers reset,
// unknown commands, timeouts and limit extremes. Random device frames,
// aborted reads and line noise follow, under several limit settings, with
// random stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_ps2_host_byte_transceiver_top;
	import ps2hbt_pkg::*;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int RAND_ITEMS = 160;
	localparam int SEGMENTS   = 4;
	localparam int HOLD_OFF   = 250;

	localparam result_t RES_QUIET = '0;
	localparam result_t RES_RD_START = '{rx_byte: 8'h00, success: 1'b0, done_res: 1'b0,
		busy_res: 1'b1, data_pull_low: 1'b0, clk_pull_low: 1'b0};
	localparam result_t RES_RD_TMO = '{rx_byte: 8'h00, success: 1'b0, done_res: 1'b1,
		busy_res: 1'b0, data_pull_low: 1'b0, clk_pull_low: 1'b1};
	localparam result_t RES_WR_TMO = '{rx_byte: 8'h00, success: 1'b0, done_res: 1'b1,
		busy_res: 1'b0, data_pull_low: 1'b1, clk_pull_low: 1'b0};

	typedef enum {ST_TICK, ST_CFG, ST_RFRAME, ST_WCLOCK} step_kind_t;

	// reps: repeat count for ticks, half period for device frames
	typedef struct {
		step_kind_t kind;
		logic       rsel;
		logic [1:0] cmd;
		logic       ten;
		logic       cl;
		logic       dl;
		int         val;
		int         reps;
		logic       fixed;
		result_t    want;
	} step_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic                cfg_we = 1'b0;
	logic                cfg_index = 1'b0;
	logic [LIMIT_W-1:0]  cfg_wdata = '0;

	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int err_cnt = 0;
	int n_sent = 0;

	result_t status_q [$];

	// sequencer model state
	phase_t             seq_ph;
	logic [3:0]         bit_pos;
	logic [7:0]         tx_shift;
	logic               par_run;
	logic [CNT_W-1:0]   wait_cnt;
	logic               tmo_on;
	logic               clk_drv;
	logic               dat_drv;
	logic [7:0]         rx_acc;
	logic [LIMIT_W-1:0] lim_wr;
	logic [LIMIT_W-1:0] lim_rd;

	step_t plan [0:23] = '{
		'{ST_TICK,   1'b0, CMD_TICK,  1'b0, 1'b1, 1'b1, 0,       3,   1'b1, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_NONE,  1'b1, 1'b0, 1'b0, 'hFF,    2,   1'b1, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_READ,  1'b1, 1'b1, 1'b1, 0,       1,   1'b1, RES_RD_START},
		'{ST_RFRAME, 1'b0, CMD_TICK,  1'b0, 1'b1, 1'b1, 'hA5,    2,   1'b0, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_READ,  1'b0, 1'b1, 1'b1, 0,       1,   1'b0, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_WRITE, 1'b1, 1'b1, 1'b0, 'h3C,    3,   1'b0, RES_QUIET},
		'{ST_RFRAME, 1'b0, CMD_TICK,  1'b0, 1'b1, 1'b1, 'h00,    1,   1'b0, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_READ,  1'b0, 1'b1, 1'b1, 0,       1,   1'b0, RES_QUIET},
		'{ST_RFRAME, 1'b0, CMD_TICK,  1'b0, 1'b1, 1'b1, 'hFF,    3,   1'b0, RES_QUIET},
		'{ST_CFG,    REG_READ_LIMIT,  CMD_TICK, 1'b0, 1'b1, 1'b1, 0, 0, 1'b0, RES_QUIET},
		'{ST_CFG,    REG_WRITE_LIMIT, CMD_TICK, 1'b0, 1'b1, 1'b1, 0, 0, 1'b0, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_READ,  1'b1, 1'b1, 1'b1, 0,       1,   1'b1, RES_RD_START},
		'{ST_TICK,   1'b0, CMD_TICK,  1'b0, 1'b1, 1'b1, 0,       1,   1'b1, RES_RD_TMO},
		'{ST_TICK,   1'b0, CMD_WRITE, 1'b1, 1'b1, 1'b1, 'h00,    1,   1'b0, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_TICK,  1'b0, 1'b1, 1'b1, 0,       610, 1'b0, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_TICK,  1'b0, 1'b1, 1'b1, 0,       1,   1'b1, RES_WR_TMO},
		'{ST_CFG,    REG_WRITE_LIMIT, CMD_TICK, 1'b0, 1'b1, 1'b1, 'hFFFFF, 0, 1'b0, RES_QUIET},
		'{ST_CFG,    REG_READ_LIMIT,  CMD_TICK, 1'b0, 1'b1, 1'b1, 'hFFFFF, 0, 1'b0, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_WRITE, 1'b1, 1'b1, 1'b1, 'hFF,    1,   1'b0, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_TICK,  1'b0, 1'b1, 1'b1, 0,       610, 1'b0, RES_QUIET},
		'{ST_WCLOCK, 1'b0, CMD_TICK,  1'b0, 1'b1, 1'b1, 0,       2,   1'b0, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_READ,  1'b1, 1'b1, 1'b1, 0,       1,   1'b0, RES_QUIET},
		'{ST_RFRAME, 1'b0, CMD_TICK,  1'b0, 1'b1, 1'b1, 'h5A,    1,   1'b0, RES_QUIET},
		'{ST_TICK,   1'b0, CMD_NONE,  1'b1, 1'b0, 1'b0, 'h81,    2,   1'b0, RES_QUIET}
	};

	ps2_host_byte_transceiver_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void tick_up();
		if (wait_cnt != CNT_MAX)
			wait_cnt++;
	endfunction

	// next data bit (index 8 is parity) onto the data line, low for a zero
	function automatic void put_bit();
		logic b;
		if (bit_pos < 8) begin
			b = tx_shift[bit_pos[2:0]];
			par_run ^= b;
		end else begin
			b = par_run;
		end
		dat_drv = !b;
	endfunction

	function automatic result_t host_step(input item_t it);
		result_t r;
		logic fin;
		logic good;
		fin = 1'b0;
		good = 1'b0;
		case (seq_ph)
			PH_IDLE: begin
				if (it.cmd == CMD_WRITE) begin
					clk_drv = 1'b0;
					dat_drv = 1'b0;
					tx_shift = it.tx_byte;
					par_run = 1'b1;
					bit_pos = '0;
					tmo_on = it.timeout_enable;
					wait_cnt = '0;
					seq_ph = PH_W_REL;
				end else if (it.cmd == CMD_READ) begin
					clk_drv = 1'b0;
					dat_drv = 1'b0;
					rx_acc = '0;
					bit_pos = '0;
					tmo_on = it.timeout_enable;
					wait_cnt = '0;
					seq_ph = PH_R_WAIT;
				end
			end
			PH_W_REL: begin
				tick_up();
				if (wait_cnt >= RELEASE_TICKS) begin
					clk_drv = 1'b1;
					wait_cnt = '0;
					seq_ph = PH_W_CLKLO;
				end
			end
			PH_W_CLKLO: begin
				tick_up();
				if (wait_cnt >= CLK_LOW_TICKS) begin
					dat_drv = 1'b1;
					wait_cnt = '0;
					seq_ph = PH_W_DATLO;
				end
			end
			PH_W_DATLO: begin
				tick_up();
				if (wait_cnt >= DATA_LOW_TICKS) begin
					clk_drv = 1'b0;
					wait_cnt = '0;
					seq_ph = PH_W_WAIT;
				end
			end
			PH_W_WAIT: begin
				tick_up();
				if (!it.clk_line) begin
					bit_pos = '0;
					put_bit();
					seq_ph = PH_W_HI;
				end else if (tmo_on && wait_cnt > lim_wr) begin
					fin = 1'b1;
					seq_ph = PH_IDLE;
				end
			end
			PH_W_HI: begin
				if (it.clk_line)
					seq_ph = PH_W_LO;
			end
			PH_W_LO: begin
				if (!it.clk_line) begin
					if (bit_pos < 8) begin
						bit_pos++;
						put_bit();
						seq_ph = PH_W_HI;
					end else begin
						wait_cnt = '0;
						seq_ph = PH_W_STOP;
					end
				end
			end
			PH_W_STOP: begin
				tick_up();
				if (wait_cnt >= STOP_TICKS) begin
					dat_drv = 1'b0;
					seq_ph = PH_W_ACK;
				end
			end
			PH_W_ACK: begin
				if (!it.clk_line)
					seq_ph = PH_W_LINEIDLE;
			end
			PH_W_LINEIDLE: begin
				if (it.clk_line && it.data_line) begin
					clk_drv = 1'b1;
					fin = 1'b1;
					good = 1'b1;
					seq_ph = PH_IDLE;
				end
			end
			PH_R_WAIT: begin
				tick_up();
				if (!it.clk_line) begin
					seq_ph = PH_R_START;
				end else if (tmo_on && wait_cnt > lim_rd) begin
					clk_drv = 1'b1;
					fin = 1'b1;
					seq_ph = PH_IDLE;
				end
			end
			PH_R_START: begin
				if (it.clk_line) begin
					bit_pos = '0;
					seq_ph = PH_R_LO;
				end
			end
			PH_R_LO: begin
				if (!it.clk_line) begin
					if (it.data_line && bit_pos < 8)
						rx_acc[bit_pos[2:0]] = 1'b1;
					seq_ph = PH_R_HI;
				end
			end
			PH_R_HI: begin
				if (it.clk_line) begin
					bit_pos++;
					seq_ph = (bit_pos >= 8) ? PH_R_PAR_LO : PH_R_LO;
				end
			end
			PH_R_PAR_LO: begin
				if (!it.clk_line)
					seq_ph = PH_R_PAR_HI;
			end
			PH_R_PAR_HI: begin
				if (it.clk_line)
					seq_ph = PH_R_STOP_LO;
			end
			PH_R_STOP_LO: begin
				if (!it.clk_line)
					seq_ph = PH_R_STOP_HI;
			end
			PH_R_STOP_HI: begin
				if (it.clk_line) begin
					clk_drv = 1'b1;
					fin = 1'b1;
					good = 1'b1;
					seq_ph = PH_IDLE;
				end
			end
			default: seq_ph = PH_IDLE;
		endcase
		r.clk_pull_low = clk_drv;
		r.data_pull_low = dat_drv;
		r.busy_res = (seq_ph != PH_IDLE);
		r.done_res = fin;
		r.success = fin & good;
		r.rx_byte = rx_acc;
		return r;
	endfunction

	function automatic void flag_err(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%s", msg);
	endfunction

	function automatic void check_status(input logic [OUT_W-1:0] w);
		result_t got;
		result_t e;
		got = result_t'(w[$bits(result_t)-1:0]);
		if (status_q.size() == 0) begin
			flag_err($sformatf("unexpected status transaction %h", w));
		end else begin
			e = status_q.pop_front();
			if (got.clk_pull_low !== e.clk_pull_low || got.data_pull_low !== e.data_pull_low
					|| got.busy_res !== e.busy_res || got.done_res !== e.done_res
					|| got.success !== e.success || got.rx_byte !== e.rx_byte
					|| w[OUT_W-1:$bits(result_t)] !== '0)
				flag_err($sformatf({"status mismatch: exp clk %0b dat %0b busy %0b done %0b ",
					"ok %0b rx %h / got clk %0b dat %0b busy %0b done %0b ok %0b rx %h pad %b"},
					e.clk_pull_low, e.data_pull_low, e.busy_res, e.done_res, e.success,
					e.rx_byte, got.clk_pull_low, got.data_pull_low, got.busy_res,
					got.done_res, got.success, got.rx_byte, w[OUT_W-1:$bits(result_t)]));
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			check_status(m_tdata);
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_OFF;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 9);
		end
	end

	// entered and left right after a rising edge
	task automatic put_item(input item_t it, input logic use_want, input result_t want);
		result_t r;
		if (!calm && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tdata <= IN_W'(it);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		r = host_step(it);
		status_q.push_back(use_want ? want : r);
		n_sent++;
	endtask

	task automatic line_tick(input logic cl, input logic dl);
		item_t it;
		if (seq_ph != PH_IDLE)
			it.cmd = 2'($urandom_range(3));
		else
			it.cmd = $urandom_range(1) ? CMD_NONE : CMD_TICK;
		it.tx_byte = 8'($urandom);
		it.timeout_enable = 1'($urandom);
		it.clk_line = cl;
		it.data_line = dl;
		put_item(it, 1'b0, RES_QUIET);
	endtask

	task automatic launch(input logic [1:0] c, input logic [7:0] b, input logic te);
		item_t it;
		it = '{data_line: 1'b1, clk_line: 1'b1, timeout_enable: te, tx_byte: b, cmd: c};
		put_item(it, 1'b0, RES_QUIET);
	endtask

	// device frame: start, 8 bits LSB first, odd parity, stop
	task automatic dev_read(input logic [7:0] b, input int h, input int lead);
		logic [10:0] frame;
		frame = {1'b1, ~^b, b, 1'b0};
		repeat (lead) line_tick(1'b1, 1'b1);
		for (int k = 0; k < 11; k++) begin
			repeat (h) line_tick(1'b0, frame[k]);
			repeat (h) line_tick(1'b1, frame[k]);
		end
	endtask

	// device clocks in 10 bits, waits out the stop time, then acknowledges
	task automatic dev_write(input int lead, input int h);
		repeat (lead) line_tick(1'b1, 1'b1);
		repeat (10) begin
			repeat (h) line_tick(1'b0, 1'($urandom));
			repeat (h) line_tick(1'b1, 1'($urandom));
		end
		repeat (STOP_TICKS + 1) line_tick(1'b1, 1'b1);
		repeat (h) line_tick(1'b0, 1'b0);
		line_tick(1'b1, 1'b1);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [LIMIT_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == REG_WRITE_LIMIT)
			lim_wr = v;
		else
			lim_rd = v;
		@(posedge clk);
	endtask

	task automatic run_sequence();
		int sel;
		logic tgl;
		sel = $urandom_range(99);
		tgl = 1'b0;
		if (sel < 60) begin
			launch(CMD_READ, 8'($urandom), 1'($urandom));
			dev_read(8'($urandom), $urandom_range(1, 4), $urandom_range(0, 16));
		end else if (sel < 85) begin
			launch(CMD_READ, 8'($urandom), 1'($urandom));
			repeat ($urandom_range(4, 30)) line_tick(1'($urandom), 1'($urandom));
		end else begin
			repeat ($urandom_range(1, 8)) line_tick(1'($urandom), 1'($urandom));
		end
		// toggling the clock line moves every phase back to idle
		while (seq_ph != PH_IDLE) begin
			line_tick(tgl, 1'b1);
			tgl = !tgl;
		end
	endtask

	initial begin
		item_t it;
		int stop_at;
		seq_ph = PH_IDLE;
		bit_pos = '0;
		tx_shift = '0;
		par_run = 1'b1;
		wait_cnt = '0;
		tmo_on = 1'b0;
		clk_drv = 1'b0;
		dat_drv = 1'b0;
		rx_acc = '0;
		lim_wr = LIMIT_W'(15000);
		lim_rd = LIMIT_W'(15000);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			case (plan[i].kind)
				ST_TICK: begin
					it = '{data_line: plan[i].dl, clk_line: plan[i].cl,
						timeout_enable: plan[i].ten, tx_byte: plan[i].val[7:0],
						cmd: plan[i].cmd};
					repeat (plan[i].reps) put_item(it, plan[i].fixed, plan[i].want);
				end
				ST_CFG:    write_reg(plan[i].rsel, plan[i].val[LIMIT_W-1:0]);
				ST_RFRAME: dev_read(plan[i].val[7:0], plan[i].reps, 1);
				ST_WCLOCK: dev_write(2, plan[i].reps);
				default: ;
			endcase
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			if (seg > 0) begin
				write_reg(REG_WRITE_LIMIT, LIMIT_W'($urandom_range(0, 12)));
				write_reg(REG_READ_LIMIT, LIMIT_W'($urandom_range(0, 12)));
			end
			if (seg == 1)
				hold_req <= 1'b1;
			calm <= (seg == 2);
			stop_at = n_sent + RAND_ITEMS / SEGMENTS;
			while (n_sent < stop_at)
				run_sequence();
		end

		settle();
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== ps2_host_byte_transceiver_top.f =====
hdl/ps2hbt_pkg.sv
hdl/ps2hbt_cfg.sv
hdl/ps2hbt_seq.sv
hdl/ps2hbt_seq_top.sv
hdl/ps2_host_byte_transceiver_top.sv
tb/tb_ps2_host_byte_transceiver_top.sv
